>>> hdl/bbn_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// No dependencies; every other file of the block but bbn_ram imports it.
package bbn_pkg;

  localparam int PIX_W         = 8;
  localparam int BLUR_W        = 12;
  localparam int IMG_W_W       = 11;
  localparam int IMG_H_W       = 12;
  localparam int ROW_W         = 13;  // input row counter reaches height + 1
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 12;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 16;
  localparam int SUM_W         = 12;
  localparam int CNT_W         = 4;
  localparam int NUM_W         = 16;  // 16 * sum + count / 2
  localparam int RECIP_W       = 21;
  localparam int RECIP_SHIFT   = 20;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 12'd480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // per-item control decided when the pixel is taken in
  typedef struct packed {
    logic             emit;
    logic             wr;
    logic             rend;
    logic             fend;
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [CNT_W-1:0] cnt;
    logic [PIX_W-1:0] bot;
  } ctl_t;

  // stage holding the scaled sum, ahead of the reciprocal multiply
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [CNT_W-1:0] cnt;
    logic             rend;
    logic             fend;
  } sum_t;

  // ceil(2^20 / count); exact quotient for any numerator below 2^16
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    unique case (cnt)
      4'd2:    r = 21'd524288;
      4'd3:    r = 21'd349526;
      4'd4:    r = 21'd262144;
      4'd6:    r = 21'd174763;
      4'd9:    r = 21'd116509;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/bbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/bbn_seq.sv
// Input side of the box blur: configuration registers, raster counters and
// the first pipeline stage. Depends on bbn_pkg.
module bbn_seq #(
  parameter int MAX_WIDTH = bbn_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bbn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbn_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bbn_pkg::PIX_W-1:0]       in_pixel,
  input  logic                            in_drain,
  output logic                            rd_fire,
  output logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
  output logic                            a_valid,
  input  logic                            a_adv,
  output bbn_pkg::ctl_t                   a_item,
  output logic [$clog2(MAX_WIDTH)-1:0]    a_addr
);
  import bbn_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);

  logic [IMG_W_W-1:0] width_r;
  logic [IMG_H_W-1:0] height_r;
  logic [COL_W-1:0]   in_col_r, in_col_nxt;
  logic [ROW_W-1:0]   in_row_r, in_row_nxt;
  logic [COL_W-1:0]   out_col_r, out_col_nxt;
  logic [IMG_H_W-1:0] out_row_r, out_row_nxt;
  logic               a_valid_r, a_valid_nxt;
  ctl_t               a_item_r;
  logic [COL_W-1:0]   a_addr_r;

  logic [WW-1:0]      eff_w;
  logic [IMG_H_W-1:0] eff_h;
  logic               complete, take, emit;
  logic [WW-1:0]      in_col_inc;
  logic [1:0]         rows, cols;
  ctl_t               item;

  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    eff_h = (height_r == '0) ? IMG_H_W'(1) : height_r;
  end

  assign complete = in_row_r >= ROW_W'(eff_h);
  assign in_ready = !a_valid_r || a_adv;
  // a drain while the frame is still arriving is swallowed
  assign take     = in_valid && in_ready && (complete || !in_drain);
  assign emit     = (in_row_r >= ROW_W'(2)) || (in_row_r == ROW_W'(1) && in_col_r != '0);

  always_comb begin
    item        = '0;
    item.emit   = emit;
    item.wr     = !complete;
    item.bot    = complete ? '0 : in_pixel;
    item.row_ok = {(ROW_W'(out_row_r) + ROW_W'(1)) < ROW_W'(eff_h), 1'b1, out_row_r != '0};
    item.col_ok = {(WW'(out_col_r) + WW'(1)) < eff_w, 1'b1, out_col_r != '0};
    item.rend   = !item.col_ok[2];
    item.fend   = item.rend && !item.row_ok[2];
    rows        = 2'(item.row_ok[0]) + 2'(item.row_ok[1]) + 2'(item.row_ok[2]);
    cols        = 2'(item.col_ok[0]) + 2'(item.col_ok[1]) + 2'(item.col_ok[2]);
    item.cnt    = CNT_W'(rows) * CNT_W'(cols);
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    in_col_inc  = WW'(in_col_r) + WW'(1);
    if (cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (emit && item.fend) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        if (emit) begin
          if (item.rend) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + IMG_H_W'(1);
          end else begin
            out_col_nxt = COL_W'(WW'(out_col_r) + WW'(1));
          end
        end
        if (in_col_inc >= eff_w) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + ROW_W'(1);
        end else begin
          in_col_nxt = COL_W'(in_col_inc);
        end
      end
    end
  end

  assign a_valid_nxt = take ? 1'b1 : (a_adv ? 1'b0 : a_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= IMG_W_RST;
      height_r  <= IMG_H_RST;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      a_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_data[IMG_W_W-1:0];
      end
      if (cfg_we && cfg_index == REG_IMAGE_HEIGHT) begin
        height_r <= cfg_data[IMG_H_W-1:0];
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_item_r <= item;
      a_addr_r <= in_col_r;
    end
  end

  assign rd_fire = take;
  assign rd_addr = in_col_r;
  assign a_valid = a_valid_r;
  assign a_item  = a_item_r;
  assign a_addr  = a_addr_r;

endmodule

>>> hdl/bbn_window.sv
// Line buffers, 3x3 window and masked neighbourhood sum of the box blur.
// Depends on bbn_pkg and bbn_ram.
module bbn_window #(
  parameter int MAX_WIDTH = bbn_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_fire,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  input  logic                          a_valid,
  output logic                          a_adv,
  input  bbn_pkg::ctl_t                 a_item,
  input  logic [$clog2(MAX_WIDTH)-1:0]  a_addr,
  output logic                          c_valid,
  input  logic                          c_ready,
  output bbn_pkg::sum_t                 c_item
);
  import bbn_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LB_W  = 2 * PIX_W;

  // each RAM word is {two rows above, row above} for one column
  logic              wr_en;
  logic [LB_W-1:0]   wr_data, rd_data, lines;
  logic              fwd_sel_r;
  logic [LB_W-1:0]   fwd_data_r;
  logic [PIX_W-1:0]  top, mid;

  logic [PIX_W-1:0]  win_r [9];
  ctl_t              b_item_r;
  logic              b_valid_r, b_valid_nxt, b_adv;
  logic              c_valid_r, c_valid_nxt, c_room, fire_ab, fire_bc;
  sum_t              c_item_r, c_nxt;
  logic [SUM_W-1:0]  sum;

  bbn_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (a_addr),
    .wr_data (wr_data),
    .rd_en   (rd_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign c_room  = !c_valid_r || c_ready;
  assign b_adv   = !b_item_r.emit || c_room;
  assign a_adv   = !b_valid_r || b_adv;
  assign fire_ab = a_valid && a_adv;
  assign fire_bc = b_valid_r && b_item_r.emit && c_room;

  // one-pixel-wide frames hit the same column on back-to-back transactions
  assign lines   = fwd_sel_r ? fwd_data_r : rd_data;
  assign top     = lines[LB_W-1:PIX_W];
  assign mid     = lines[PIX_W-1:0];
  assign wr_en   = fire_ab && a_item.wr;
  assign wr_data = {mid, a_item.bot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sel_r <= 1'b0;
    end else if (rd_fire) begin
      fwd_sel_r <= wr_en && (rd_addr == a_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      fwd_data_r <= wr_data;
    end
  end

  assign b_valid_nxt = fire_ab ? 1'b1 : (b_adv ? 1'b0 : b_valid_r);
  assign c_valid_nxt = fire_bc ? 1'b1 : (c_ready ? 1'b0 : c_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      b_valid_r <= b_valid_nxt;
      c_valid_r <= c_valid_nxt;
      if (fire_ab) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i*3+0] <= win_r[i*3+1];
          win_r[i*3+1] <= win_r[i*3+2];
        end
        win_r[2] <= top;
        win_r[5] <= mid;
        win_r[8] <= a_item.bot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_ab) begin
      b_item_r <= a_item;
    end
    if (fire_bc) begin
      c_item_r <= c_nxt;
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (b_item_r.row_ok[i] && b_item_r.col_ok[j]) begin
          sum = sum + SUM_W'(win_r[i*3+j]);
        end
      end
    end
    c_nxt.num  = {sum, 4'b0000} + NUM_W'(b_item_r.cnt >> 1);
    c_nxt.cnt  = b_item_r.cnt;
    c_nxt.rend = b_item_r.rend;
    c_nxt.fend = b_item_r.fend;
  end

  assign c_valid = c_valid_r;
  assign c_item  = c_item_r;

endmodule

>>> hdl/bbn_norm.sv
// Output stage of the box blur: divides the rounded sum by the neighbour
// count through a reciprocal multiply. Depends on bbn_pkg.
module bbn_norm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         c_valid,
  output logic                         c_ready,
  input  bbn_pkg::sum_t                c_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bbn_pkg::BLUR_W-1:0]   blurred,
  output logic                         row_end,
  output logic                         frame_end
);
  import bbn_pkg::*;

  logic [NUM_W+RECIP_W-1:0] prod;
  logic                     valid_r, valid_nxt, fire;
  logic [BLUR_W-1:0]        blurred_r;
  logic                     rend_r, fend_r;

  assign c_ready   = !valid_r || out_ready;
  assign fire      = c_valid && c_ready;
  assign prod      = (NUM_W+RECIP_W)'(c_item.num) * (NUM_W+RECIP_W)'(recip(c_item.cnt));
  assign valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      blurred_r <= prod[RECIP_SHIFT +: BLUR_W];
      rend_r    <= c_item.rend;
      fend_r    <= c_item.fend;
    end
  end

  assign out_valid = valid_r;
  assign blurred   = blurred_r;
  assign row_end   = rend_r;
  assign frame_end = fend_r;

endmodule

>>> hdl/box_blur_3x3_edge_normalized.sv
// Top level of the streaming 3x3 box blur with edge-normalised mean.
// Depends on bbn_pkg, bbn_seq, bbn_window, bbn_norm and bbn_ram.
//
// Pixels of one 8-bit frame enter in raster order on the in_ stream; the
// out_ stream gives the 3x3 mean of each pixel as unsigned 8.4, rounded to
// nearest, over the neighbours inside the frame (9, 6 or 4 of them; 3, 2 or 1 in a frame one pixel wide or high).
// The result for pixel k is produced by the transaction with stream index
// k + width + 1; drain transactions (in_tuser set) push out the frame tail
// and are dropped while the frame is still arriving.
// A result passes the a, b and c stage registers and the output register
// of bbn_norm. Throughput: one transaction per cycle while out_tready is
// high, set by the single read and single write port of the line-buffer RAM.
// cfg_ writes set image_width (index 0) and image_height (index 1) and
// restart the frame; write only while the pipe is empty.
// Reset: width 640, height 480, counters and window cleared; the line
// buffers are not cleared, reads of unwritten columns only feed masked
// neighbours. When out_tready is low the four pipeline stages fill and
// in_tready drops only once all of them hold a transaction.
module box_blur_3x3_edge_normalized #(
  parameter int MAX_WIDTH = bbn_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bbn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbn_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bbn_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] pixel
  input  logic [0:0]                        in_tuser,   // [0] drain
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bbn_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [11:0] blurred, [15:12] zero
  output logic                              out_tlast,  // row_end
  output logic [0:0]                        out_tuser   // [0] frame_end
);
  import bbn_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic              rd_fire, a_valid, a_adv, c_valid, c_ready;
  logic [COL_W-1:0]  rd_addr, a_addr;
  ctl_t              a_item;
  sum_t              c_item;
  logic [BLUR_W-1:0] blurred;
  logic              frame_end;

  bbn_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pixel  (in_tdata[PIX_W-1:0]),
    .in_drain  (in_tuser[0]),
    .rd_fire   (rd_fire),
    .rd_addr   (rd_addr),
    .a_valid   (a_valid),
    .a_adv     (a_adv),
    .a_item    (a_item),
    .a_addr    (a_addr)
  );

  bbn_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_fire (rd_fire),
    .rd_addr (rd_addr),
    .a_valid (a_valid),
    .a_adv   (a_adv),
    .a_item  (a_item),
    .a_addr  (a_addr),
    .c_valid (c_valid),
    .c_ready (c_ready),
    .c_item  (c_item)
  );

  bbn_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .c_valid   (c_valid),
    .c_ready   (c_ready),
    .c_item    (c_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .blurred   (blurred),
    .row_end   (out_tlast),
    .frame_end (frame_end)
  );

  assign out_tdata    = OUT_TDATA_W'(blurred);
  assign out_tuser[0] = frame_end;

  // a free output side must never back-pressure the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while out_tready high");

  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("frame_end without row_end");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[BLUR_W-1:0] <= 12'd4080 && out_tdata[OUT_TDATA_W-1:BLUR_W] == '0))
    else $error("blurred value out of range");

endmodule
